@@ src/esst_pkg.sv @@
// Shared types, widths, register indexes and mode codes of the event state stepper.
package esst_pkg;

	// Field and register widths.
	localparam int unsigned TICK_W    = 48;
	localparam int unsigned PITCH_W   = 7;
	localparam int unsigned IDX_W     = 4;
	localparam int unsigned MODE_W    = 3;
	localparam int unsigned NS_W      = 5;
	localparam int unsigned START_W   = 4;
	localparam int unsigned BCNT_W    = 10;
	localparam int unsigned TPB_W     = 16;
	localparam int unsigned BPB_W     = 8;
	localparam int unsigned MASK_W    = 64;
	localparam int unsigned CFG_W     = 64;
	localparam int unsigned CFG_IDX_W = 3;

	// Datapath widths of the beat unit.
	localparam int unsigned UNIT_W    = TPB_W + BPB_W;
	localparam int unsigned PERIOD_W  = UNIT_W + BCNT_W;
	localparam int unsigned MUL_STEPS = BCNT_W;
	localparam int unsigned DIV_STEPS = TICK_W;
	localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

	localparam int unsigned MAX_STATES_DEF = 16;

	// Register indexes on the write port.
	localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_STATES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BEAT_COUNT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TPB        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BPB        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_LO    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_HI    = 3'd7;

	// Mode codes; the two remaining codes behave like MODE_OFF.
	localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_EVERY = 3'd1;
	localparam logic [MODE_W-1:0] MODE_NEW   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_LIST  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_BEATS = 3'd4;
	localparam logic [MODE_W-1:0] MODE_BARS  = 3'd5;

	// Reset values of the registers.
	localparam logic [BCNT_W-1:0] BEAT_COUNT_RST = 10'd1;
	localparam logic [TPB_W-1:0]  TPB_RST        = 16'd960;
	localparam logic [BPB_W-1:0]  BPB_RST        = 8'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_WALK,
		ST_BEAT,
		ST_DONE
	} st_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_MUL,
		PH_DIV,
		PH_FIN
	} phase_t;

	typedef struct packed {
		logic go;
		logic bar_mode;
	} beat_req_t;

	typedef struct packed {
		logic            done;
		logic [NS_W-1:0] idx;
	} beat_rsp_t;

endpackage

@@ src/esst_if.sv @@
// Handshake interfaces for the trigger and result channels.
interface esst_trig_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [esst_pkg::TICK_W-1:0]     tick;
	logic        [esst_pkg::PITCH_W-1:0]    pitch;
	logic                                   first_of_list;

	modport source(output valid, output tick, output pitch, output first_of_list, input ready);
	modport sink(input valid, input tick, input pitch, input first_of_list, output ready);
endinterface

interface esst_res_if;
	logic                           valid;
	logic                           ready;
	logic [esst_pkg::IDX_W-1:0]     state_index;

	modport source(output valid, output state_index, input ready);
	modport sink(input valid, input state_index, output ready);
endinterface

@@ src/esst_beat.sv @@
// Bit-serial period multiply and restoring divide giving the beat-mode state index.
module esst_beat (
	input  logic                                clk,
	input  logic                                arst_n,
	input  esst_pkg::beat_req_t                 req,
	input  logic signed [esst_pkg::TICK_W-1:0]  tick,
	input  logic [esst_pkg::TPB_W-1:0]          ticks_per_beat,
	input  logic [esst_pkg::BPB_W-1:0]          beats_per_bar,
	input  logic [esst_pkg::BCNT_W-1:0]         beat_count,
	input  logic [esst_pkg::NS_W-1:0]           n,
	input  logic [esst_pkg::NS_W-1:0]           start,
	output esst_pkg::beat_rsp_t                 rsp
);

	esst_pkg::phase_t phase_q, phase_d;

	logic [esst_pkg::PERIOD_W-1:0] mcand_q;
	logic [esst_pkg::PERIOD_W-1:0] period_q;
	logic [esst_pkg::BCNT_W-1:0]   mult_q;
	logic [esst_pkg::TICK_W-1:0]   dvd_q;
	logic [esst_pkg::PERIOD_W-1:0] rem_q;
	logic [esst_pkg::NS_W-1:0]     qm_q;
	logic                          neg_q;
	logic [esst_pkg::STEP_W-1:0]   step_q;

	logic [esst_pkg::BPB_W-1:0]    bpb1;
	logic [esst_pkg::UNIT_W-1:0]   bar_prod;
	logic [esst_pkg::UNIT_W-1:0]   unit;
	logic [esst_pkg::PERIOD_W:0]   trial;
	logic [esst_pkg::PERIOD_W:0]   diff;
	logic                          ge;
	logic [esst_pkg::NS_W:0]       dbl;
	logic [esst_pkg::NS_W-1:0]     kmod;
	logic [esst_pkg::NS_W:0]       sum;
	logic                          last_mul;
	logic                          last_div;

	// Unit period: one beat, or one bar, never below one tick.
	always_comb begin
		bpb1     = (beats_per_bar == '0) ? esst_pkg::BPB_W'(1) : beats_per_bar;
		bar_prod = esst_pkg::UNIT_W'(ticks_per_beat) * esst_pkg::UNIT_W'(bpb1);
		if (req.bar_mode) begin
			unit = (bar_prod == '0) ? esst_pkg::UNIT_W'(1) : bar_prod;
		end else begin
			unit = (ticks_per_beat == '0) ? esst_pkg::UNIT_W'(1)
			                              : esst_pkg::UNIT_W'(ticks_per_beat);
		end
	end

	// One quotient bit per cycle; the quotient is only kept modulo n.
	always_comb begin
		trial = {rem_q, dvd_q[esst_pkg::TICK_W-1]};
		diff  = trial - {1'b0, period_q};
		ge    = (trial >= {1'b0, period_q});
		dbl   = {qm_q, ge};
		kmod  = neg_q ? (n - 1'b1 - qm_q) : qm_q;
		sum   = {1'b0, kmod} + {1'b0, start};
	end

	assign last_mul = (step_q == esst_pkg::STEP_W'(esst_pkg::MUL_STEPS - 1));
	assign last_div = (step_q == esst_pkg::STEP_W'(esst_pkg::DIV_STEPS - 1));

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			esst_pkg::PH_IDLE: begin
				if (req.go) phase_d = esst_pkg::PH_MUL;
			end
			esst_pkg::PH_MUL: begin
				if (last_mul) phase_d = esst_pkg::PH_DIV;
			end
			esst_pkg::PH_DIV: begin
				if (last_div) phase_d = esst_pkg::PH_FIN;
			end
			esst_pkg::PH_FIN: begin
				phase_d = esst_pkg::PH_IDLE;
			end
			default: begin
				phase_d = esst_pkg::PH_IDLE;
			end
		endcase
	end

	always_comb begin
		rsp.done = (phase_q == esst_pkg::PH_FIN);
		rsp.idx  = (sum >= {1'b0, n}) ? esst_pkg::NS_W'(sum - {1'b0, n})
		                              : sum[esst_pkg::NS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= esst_pkg::PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			esst_pkg::PH_IDLE: begin
				mcand_q  <= esst_pkg::PERIOD_W'(unit);
				mult_q   <= (beat_count == '0) ? esst_pkg::BCNT_W'(1) : beat_count;
				period_q <= '0;
				step_q   <= '0;
				rem_q    <= '0;
				qm_q     <= '0;
				// A negative tick is divided as its complement; floor is restored at the end.
				neg_q    <= tick[esst_pkg::TICK_W-1];
				dvd_q    <= tick[esst_pkg::TICK_W-1] ? ~tick : tick;
			end
			esst_pkg::PH_MUL: begin
				if (mult_q[0]) period_q <= period_q + mcand_q;
				mcand_q <= mcand_q << 1;
				mult_q  <= mult_q >> 1;
				step_q  <= last_mul ? '0 : step_q + 1'b1;
			end
			esst_pkg::PH_DIV: begin
				rem_q  <= ge ? diff[esst_pkg::PERIOD_W-1:0] : trial[esst_pkg::PERIOD_W-1:0];
				dvd_q  <= dvd_q << 1;
				qm_q   <= (dbl >= {1'b0, n}) ? esst_pkg::NS_W'(dbl - {1'b0, n})
				                             : dbl[esst_pkg::NS_W-1:0];
				step_q <= step_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ src/event_state_stepper.sv @@
// Top level of the event state stepper: registers, walk sequencer and result register.
// A walked mode first reduces a stale state index modulo the state count by serial
// subtraction, then steps. Beat and bar modes run the 10-step shift-add multiply and
// 48-step divide in esst_beat; off and single-state cases go straight to the result. One
// item is in work at a time; the next is taken in the cycle after its result is registered.
// Reset clears the control, configuration, history and output-valid registers, not the data.
module event_state_stepper (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [esst_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [esst_pkg::CFG_W-1:0]        wr_data,
	esst_trig_if.sink                         trig,
	esst_res_if.source                        result
);

	// Configuration registers.
	logic [esst_pkg::MODE_W-1:0]  mode_q;
	logic [esst_pkg::NS_W-1:0]    num_states_q;
	logic [esst_pkg::START_W-1:0] start_state_q;
	logic [esst_pkg::BCNT_W-1:0]  beat_count_q;
	logic [esst_pkg::TPB_W-1:0]   tpb_q;
	logic [esst_pkg::BPB_W-1:0]   bpb_q;

	// The 128-pitch whitelist is held as two 64-bit rows, one read per item.
	logic [esst_pkg::MASK_W-1:0]  mask_mem [2];
	logic [esst_pkg::MASK_W-1:0]  mask_row_q;

	// Item held for the duration of its work.
	logic signed [esst_pkg::TICK_W-1:0] tick_q;
	logic [esst_pkg::PITCH_W-1:0]       pitch_q;
	logic                               first_q;

	// History carried from one item to the next.
	logic [esst_pkg::IDX_W-1:0]   current_state_q;
	logic                         seen_q;
	logic [esst_pkg::PITCH_W-1:0] last_pitch_q;

	// Working values.
	logic [esst_pkg::NS_W-1:0]    n_q;
	logic [esst_pkg::NS_W-1:0]    start_q;
	logic [esst_pkg::NS_W-1:0]    wcur_q;
	logic [esst_pkg::NS_W-1:0]    res_q;

	// Output register.
	logic                         out_valid_q;
	logic [esst_pkg::IDX_W-1:0]   out_idx_q;

	esst_pkg::st_t      state_q, state_d;
	esst_pkg::beat_req_t beat_req;
	esst_pkg::beat_rsp_t beat_rsp;

	logic                         take;
	logic                         deliver;
	logic                         many;
	logic                         beat_mode;
	logic [esst_pkg::NS_W-1:0]    n_eff;
	logic [esst_pkg::NS_W-1:0]    start_eff;
	logic                         reduced;
	logic                         adv;
	logic [esst_pkg::NS_W-1:0]    inc;
	logic [esst_pkg::NS_W-1:0]    wrapped;
	logic [esst_pkg::NS_W-1:0]    walk_next;

	// The state count saturates at MAX_STATES_DEF; the start index is clamped below it.
	always_comb begin
		n_eff = (num_states_q > esst_pkg::MAX_STATES_DEF)
		        ? esst_pkg::NS_W'(esst_pkg::MAX_STATES_DEF) : num_states_q;
		many  = (n_eff >= esst_pkg::NS_W'(2));
		if (!many) begin
			start_eff = '0;
		end else if ({1'b0, start_state_q} > (n_eff - 1'b1)) begin
			start_eff = n_eff - 1'b1;
		end else begin
			start_eff = {1'b0, start_state_q};
		end
		beat_mode = (mode_q == esst_pkg::MODE_BEATS) || (mode_q == esst_pkg::MODE_BARS);
	end

	// Walk step: the index only moves once it has been reduced below the state count.
	always_comb begin
		reduced = (wcur_q < n_q);
		case (mode_q)
			esst_pkg::MODE_EVERY: adv = seen_q;
			esst_pkg::MODE_NEW:   adv = seen_q && (pitch_q != last_pitch_q);
			default:              adv = mask_row_q[pitch_q[esst_pkg::PITCH_W-2:0]];
		endcase
		inc       = wcur_q + 1'b1;
		wrapped   = (inc >= n_q) ? '0 : inc;
		walk_next = adv ? wrapped : wcur_q;
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			esst_pkg::ST_IDLE: begin
				if (trig.valid) state_d = esst_pkg::ST_PREP;
			end
			esst_pkg::ST_PREP: begin
				if (!many) begin
					state_d = esst_pkg::ST_DONE;
				end else if (beat_mode) begin
					state_d = esst_pkg::ST_BEAT;
				end else if (mode_q inside {esst_pkg::MODE_EVERY, esst_pkg::MODE_NEW,
				                            esst_pkg::MODE_LIST}) begin
					state_d = esst_pkg::ST_WALK;
				end else begin
					state_d = esst_pkg::ST_DONE;
				end
			end
			esst_pkg::ST_WALK: begin
				if (reduced) state_d = esst_pkg::ST_DONE;
			end
			esst_pkg::ST_BEAT: begin
				if (beat_rsp.done) state_d = esst_pkg::ST_DONE;
			end
			esst_pkg::ST_DONE: begin
				if (deliver) state_d = esst_pkg::ST_IDLE;
			end
			default: begin
				state_d = esst_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs. A finished result moves into the output register once it is free,
	// so the next item can be taken while that result still waits for its transfer.
	always_comb begin
		take              = (state_q == esst_pkg::ST_IDLE);
		deliver           = (state_q == esst_pkg::ST_DONE) && (!out_valid_q || result.ready);
		beat_req.go       = (state_q == esst_pkg::ST_PREP) && many && beat_mode;
		beat_req.bar_mode = (mode_q == esst_pkg::MODE_BARS);
	end

	assign trig.ready         = take;
	assign result.valid       = out_valid_q;
	assign result.state_index = out_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= esst_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes; the user must make them only while the block is idle, as the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= esst_pkg::MODE_OFF;
			num_states_q  <= '0;
			start_state_q <= '0;
			beat_count_q  <= esst_pkg::BEAT_COUNT_RST;
			tpb_q         <= esst_pkg::TPB_RST;
			bpb_q         <= esst_pkg::BPB_RST;
			mask_mem[0]   <= '0;
			mask_mem[1]   <= '0;
		end else if (wr_en) begin
			case (wr_index)
				esst_pkg::REG_MODE:       mode_q        <= wr_data[esst_pkg::MODE_W-1:0];
				esst_pkg::REG_NUM_STATES: num_states_q  <= wr_data[esst_pkg::NS_W-1:0];
				esst_pkg::REG_START:      start_state_q <= wr_data[esst_pkg::START_W-1:0];
				esst_pkg::REG_BEAT_COUNT: beat_count_q  <= wr_data[esst_pkg::BCNT_W-1:0];
				esst_pkg::REG_TPB:        tpb_q         <= wr_data[esst_pkg::TPB_W-1:0];
				esst_pkg::REG_BPB:        bpb_q         <= wr_data[esst_pkg::BPB_W-1:0];
				esst_pkg::REG_MASK_LO:    mask_mem[0]   <= wr_data[esst_pkg::MASK_W-1:0];
				esst_pkg::REG_MASK_HI:    mask_mem[1]   <= wr_data[esst_pkg::MASK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// History. A list start reloads the walked index and forgets the previous note before
	// the item is resolved; every delivered item then becomes the previous note.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_state_q <= '0;
			seen_q          <= 1'b0;
			last_pitch_q    <= '0;
		end else begin
			if ((state_q == esst_pkg::ST_PREP) && first_q) begin
				current_state_q <= start_eff[esst_pkg::IDX_W-1:0];
				seen_q          <= 1'b0;
			end
			if ((state_q == esst_pkg::ST_WALK) && reduced) begin
				current_state_q <= walk_next[esst_pkg::IDX_W-1:0];
			end
			if (deliver) begin
				seen_q       <= 1'b1;
				last_pitch_q <= pitch_q;
			end
		end
	end

	// Item payload and working registers.
	always_ff @(posedge clk) begin
		if (take && trig.valid) begin
			tick_q  <= trig.tick;
			pitch_q <= trig.pitch;
			first_q <= trig.first_of_list;
		end
		case (state_q)
			esst_pkg::ST_PREP: begin
				n_q        <= n_eff;
				start_q    <= start_eff;
				mask_row_q <= mask_mem[pitch_q[esst_pkg::PITCH_W-1]];
				wcur_q     <= first_q ? start_eff
				                      : esst_pkg::NS_W'(current_state_q);
				res_q      <= '0;
			end
			esst_pkg::ST_WALK: begin
				// A stale index left by a smaller state count is brought into range first.
				if (reduced) begin
					res_q <= walk_next;
				end else begin
					wcur_q <= wcur_q - n_q;
				end
			end
			esst_pkg::ST_BEAT: begin
				if (beat_rsp.done) res_q <= beat_rsp.idx;
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (deliver) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (deliver) out_idx_q <= res_q[esst_pkg::IDX_W-1:0];
	end

	esst_beat u_beat (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (beat_req),
		.tick           (tick_q),
		.ticks_per_beat (tpb_q),
		.beats_per_bar  (bpb_q),
		.beat_count     (beat_count_q),
		.n              (n_q),
		.start          (start_q),
		.rsp            (beat_rsp)
	);

endmodule

@@ src/esst_chk.sv @@
// Port-level checker for the event state stepper and its bind to the top level.
module esst_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          trig_valid,
	input logic                          trig_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [esst_pkg::IDX_W-1:0]    res_index
);

	logic       trig_xfer;
	logic       res_xfer;
	logic [1:0] pending_q;

	assign trig_xfer = trig_valid && trig_ready;
	assign res_xfer  = res_valid && res_ready;

	// Items taken whose result has not yet been transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {1'b0, trig_xfer} - {1'b0, res_xfer};
		end
	end

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !res_valid)
		else $error("result valid during reset");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer |-> pending_q != 2'd0)
		else $error("result transferred with no item outstanding");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two items outstanding");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		trig_xfer |=> !trig_ready)
		else $error("new item taken while one is in work");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_index))
		else $error("stalled result changed");

endmodule

bind event_state_stepper esst_chk u_esst_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.trig_valid (trig.valid),
	.trig_ready (trig.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_index  (result.state_index)
);

@@ tb/event_state_stepper_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the event state stepper with its own state predictor.
module event_state_stepper_test;

	// The two mode codes that the package leaves unnamed; both must act like the off mode.
	localparam logic [esst_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd6;
	localparam logic [esst_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd7;

	localparam logic signed [esst_pkg::TICK_W-1:0] TICK_MIN = 48'sh8000_0000_0000;
	localparam logic signed [esst_pkg::TICK_W-1:0] TICK_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam int unsigned RESET_CYCLES  = 7;
	localparam int unsigned TARGET_EVENTS = 1150;
	// The slowest transfer waits on the beat divide, the longest sender gap and the long
	// receiver hold-off, so this limit leaves a wide margin.
	localparam int unsigned QUIET_LIMIT   = 4000;
	localparam int unsigned LONG_HOLD     = 250;

	typedef struct {
		logic signed [esst_pkg::TICK_W-1:0]  tick;
		logic        [esst_pkg::PITCH_W-1:0] pitch;
		logic                                first;
	} trigger_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                           wr_en;
	logic [esst_pkg::CFG_IDX_W-1:0] wr_index;
	logic [esst_pkg::CFG_W-1:0]     wr_data;

	esst_trig_if trig_ch();
	esst_res_if  res_ch();

	event_state_stepper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.trig     (trig_ch),
		.result   (res_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the configuration registers, updated as each write is issued.
	logic [esst_pkg::MODE_W-1:0]  cfg_mode;
	logic [esst_pkg::NS_W-1:0]    cfg_num_states;
	logic [esst_pkg::START_W-1:0] cfg_start;
	logic [esst_pkg::BCNT_W-1:0]  cfg_beat_count;
	logic [esst_pkg::TPB_W-1:0]   cfg_tpb;
	logic [esst_pkg::BPB_W-1:0]   cfg_bpb;
	logic [esst_pkg::MASK_W-1:0]  cfg_mask_lo;
	logic [esst_pkg::MASK_W-1:0]  cfg_mask_hi;

	// Predicted history of the block: the walked state, whether this list has seen an
	// event yet, and the pitch of the previous event.
	logic [esst_pkg::IDX_W-1:0]   walk_state;
	logic                         seen_prev;
	logic [esst_pkg::PITCH_W-1:0] last_pitch;

	trigger_t                    pending_triggers[$];
	logic [esst_pkg::IDX_W-1:0]  expected_states[$];
	int unsigned                 triggers_queued;
	int unsigned                 results_checked;
	int unsigned                 mismatches;
	int unsigned                 send_gap;
	int unsigned                 stall_left;
	int unsigned                 hold_left;
	int unsigned                 next_hold_at;
	int unsigned                 quiet_cycles;
	logic                        no_idle;
	trigger_t                    launch;
	logic [esst_pkg::IDX_W-1:0]  want;

	// Length of one step of the beat and bar modes. A zero unit count, beat count or
	// bar length counts as one, and the bar unit is floored at one tick.
	function automatic longint beat_period();
		longint unit_len;
		longint count;
		unit_len = (cfg_tpb == 0) ? 64'sd1 : longint'(cfg_tpb);
		count    = (cfg_beat_count == 0) ? 64'sd1 : longint'(cfg_beat_count);
		if (cfg_mode == esst_pkg::MODE_BARS) begin
			unit_len = longint'(cfg_tpb) * ((cfg_bpb == 0) ? 64'sd1 : longint'(cfg_bpb));
			if (unit_len < 1)
				unit_len = 1;
		end
		return unit_len * count;
	endfunction

	// Works out the state index of one accepted trigger and moves the history on.
	function automatic logic [esst_pkg::IDX_W-1:0] resolve_state(
		input logic signed [esst_pkg::TICK_W-1:0] tick,
		input logic [esst_pkg::PITCH_W-1:0] pitch,
		input logic first
	);
		int n;
		int start;
		int cur;
		logic adv;
		logic [2*esst_pkg::MASK_W-1:0] whitelist;
		longint t;
		longint period;
		longint k;
		longint m;
		logic [esst_pkg::IDX_W-1:0] idx;
		idx = '0;
		n = int'(cfg_num_states);
		if (n > int'(esst_pkg::MAX_STATES_DEF))
			n = int'(esst_pkg::MAX_STATES_DEF);
		start = int'(cfg_start);
		if (n >= 2 && start > n - 1)
			start = n - 1;
		if (n < 2)
			start = 0;
		// A list start reloads the walk, whatever the mode.
		if (first) begin
			walk_state = start[esst_pkg::IDX_W-1:0];
			seen_prev  = 1'b0;
		end
		if (n >= 2) begin
			if (cfg_mode == esst_pkg::MODE_BEATS || cfg_mode == esst_pkg::MODE_BARS) begin
				// Floor division, so negative ticks round toward minus infinity.
				t = tick;
				period = beat_period();
				k = t / period;
				if (t < 0 && (t % period) != 0)
					k = k - 1;
				m = (k + longint'(start)) % longint'(n);
				if (m < 0)
					m = m + longint'(n);
				idx = m[esst_pkg::IDX_W-1:0];
			end else if (cfg_mode == esst_pkg::MODE_EVERY || cfg_mode == esst_pkg::MODE_NEW ||
					cfg_mode == esst_pkg::MODE_LIST) begin
				// A stale index left from other settings is folded into range first.
				cur = int'(walk_state) % n;
				whitelist = {cfg_mask_hi, cfg_mask_lo};
				case (cfg_mode)
					esst_pkg::MODE_EVERY: adv = seen_prev;
					esst_pkg::MODE_NEW:   adv = seen_prev && (pitch != last_pitch);
					default:              adv = whitelist[pitch];
				endcase
				if (adv)
					cur = (cur + 1 >= n) ? 0 : cur + 1;
				walk_state = cur[esst_pkg::IDX_W-1:0];
				idx = cur[esst_pkg::IDX_W-1:0];
			end
		end
		seen_prev  = 1'b1;
		last_pitch = pitch;
		return idx;
	endfunction

	// Idle length for either side: mostly none, some short, a few long. A phase may
	// turn idling off altogether to get back-to-back transfers.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Sender. A trigger stays on the channel until its transfer; then the next one is
	// offered at once or after a random gap. The expected state is computed at the
	// transfer itself, from exactly what the block took.
	always @(posedge clk) begin
		if (arst_n) begin
			if (trig_ch.valid && trig_ch.ready) begin
				expected_states.insert(expected_states.size(),
					resolve_state(trig_ch.tick, trig_ch.pitch, trig_ch.first_of_list));
			end
			if (!trig_ch.valid || trig_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					trig_ch.valid <= 1'b0;
				end else if (pending_triggers.size() > 0) begin
					launch = pending_triggers.pop_front();
					trig_ch.valid         <= 1'b1;
					trig_ch.tick          <= launch.tick;
					trig_ch.pitch         <= launch.pitch;
					trig_ch.first_of_list <= launch.first;
					send_gap = pick_gap();
				end else begin
					trig_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver and checker. Every result transfer is matched against the oldest
	// expected state. Now and then, while plenty of triggers are still waiting, the
	// receiver holds ready low for a long stretch so the block backs up and stalls
	// its trigger input.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_states.size() == 0) begin
					$display("%0t: result with nothing expected: state_index %0d",
						$time, res_ch.state_index);
					mismatches++;
				end else begin
					want = expected_states.pop_front();
					if (res_ch.state_index !== want) begin
						$display("%0t: state_index mismatch: expected %0d, actual %0d",
							$time, want, res_ch.state_index);
						mismatches++;
					end
				end
				results_checked++;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (results_checked >= next_hold_at && pending_triggers.size() > 8) begin
				hold_left = LONG_HOLD;
				next_hold_at = results_checked + 300;
				res_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// Watchdog: a long run of cycles without any transfer means the block has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((trig_ch.valid && trig_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("event_state_stepper_test NOT OK");
				$finish;
			end
		end
	end

	// One register write: the enable is high for exactly one rising edge.
	task automatic write_reg(input logic [esst_pkg::CFG_IDX_W-1:0] idx,
			input logic [esst_pkg::CFG_W-1:0] data);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		case (idx)
			esst_pkg::REG_MODE:       cfg_mode       = data[esst_pkg::MODE_W-1:0];
			esst_pkg::REG_NUM_STATES: cfg_num_states = data[esst_pkg::NS_W-1:0];
			esst_pkg::REG_START:      cfg_start      = data[esst_pkg::START_W-1:0];
			esst_pkg::REG_BEAT_COUNT: cfg_beat_count = data[esst_pkg::BCNT_W-1:0];
			esst_pkg::REG_TPB:        cfg_tpb        = data[esst_pkg::TPB_W-1:0];
			esst_pkg::REG_BPB:        cfg_bpb        = data[esst_pkg::BPB_W-1:0];
			esst_pkg::REG_MASK_LO:    cfg_mask_lo    = data[esst_pkg::MASK_W-1:0];
			esst_pkg::REG_MASK_HI:    cfg_mask_hi    = data[esst_pkg::MASK_W-1:0];
			default: begin
			end
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_walk(input logic [esst_pkg::MODE_W-1:0] mode, input int n,
			input int start);
		write_reg(esst_pkg::REG_MODE, esst_pkg::CFG_W'(mode));
		write_reg(esst_pkg::REG_NUM_STATES, esst_pkg::CFG_W'(n));
		write_reg(esst_pkg::REG_START, esst_pkg::CFG_W'(start));
	endtask

	task automatic queue_trigger(input logic signed [esst_pkg::TICK_W-1:0] tick,
			input logic [esst_pkg::PITCH_W-1:0] pitch, input logic first);
		trigger_t ev;
		ev.tick  = tick;
		ev.pitch = pitch;
		ev.first = first;
		pending_triggers.insert(pending_triggers.size(), ev);
		triggers_queued++;
	endtask

	// Waits until every queued trigger has been sent and every result has come back.
	// Sampling on the falling edge keeps this clear of the sender's own updates.
	task automatic wait_idle();
		while (pending_triggers.size() != 0 || trig_ch.valid || expected_states.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic signed [esst_pkg::TICK_W-1:0] random_tick();
		logic [63:0] raw;
		longint t;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0:       return TICK_MIN;
			1:       return TICK_MAX;
			2, 3, 4: return raw[esst_pkg::TICK_W-1:0];
			default: begin
				t = longint'($urandom_range(0, 20000)) - 10000;
				return t[esst_pkg::TICK_W-1:0];
			end
		endcase
	endfunction

	// Ticks placed on and around step boundaries, on both sides of zero.
	function automatic logic signed [esst_pkg::TICK_W-1:0] beat_tick();
		longint period;
		longint k;
		longint t;
		period = beat_period();
		k = longint'($urandom_range(0, 400)) - 200;
		case ($urandom_range(0, 3))
			0:       t = k * period;
			1:       t = k * period - 1;
			2:       t = k * period + 1;
			default: t = k * period + (longint'($urandom) % period);
		endcase
		return t[esst_pkg::TICK_W-1:0];
	endfunction

	function automatic logic [esst_pkg::MODE_W-1:0] pick_mode();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15) return esst_pkg::MODE_EVERY;
		if (r < 30) return esst_pkg::MODE_NEW;
		if (r < 45) return esst_pkg::MODE_LIST;
		if (r < 62) return esst_pkg::MODE_BEATS;
		if (r < 80) return esst_pkg::MODE_BARS;
		if (r < 88) return esst_pkg::MODE_OFF;
		if (r < 94) return MODE_SPARE_A;
		return MODE_SPARE_B;
	endfunction

	function automatic logic [esst_pkg::MASK_W-1:0] pick_mask();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 6) return {$urandom, $urandom};
		if (r < 8) return {$urandom, $urandom} & {$urandom, $urandom};
		if (r < 9) return '0;
		return '1;
	endfunction

	// One random phase: a random subset of the registers is rewritten (registers left
	// alone keep their values, and so does the walked state), then a batch of triggers
	// shaped for the mode in force.
	task automatic random_phase();
		int unsigned r;
		int len;
		int list_len;
		logic [esst_pkg::PITCH_W-1:0] pool [3];
		logic [63:0] raw;
		logic first;
		logic [esst_pkg::PITCH_W-1:0] pitch;
		no_idle = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 9) < 8)
			write_reg(esst_pkg::REG_MODE, esst_pkg::CFG_W'(pick_mode()));
		if ($urandom_range(0, 9) < 6) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				write_reg(esst_pkg::REG_NUM_STATES, esst_pkg::CFG_W'($urandom_range(2, 16)));
			else if (r < 88)
				write_reg(esst_pkg::REG_NUM_STATES, esst_pkg::CFG_W'($urandom_range(0, 1)));
			else
				write_reg(esst_pkg::REG_NUM_STATES, esst_pkg::CFG_W'($urandom_range(17, 31)));
		end
		if ($urandom_range(0, 9) < 6)
			write_reg(esst_pkg::REG_START, esst_pkg::CFG_W'($urandom_range(0, 15)));
		if ($urandom_range(0, 9) < 6) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				write_reg(esst_pkg::REG_BEAT_COUNT, esst_pkg::CFG_W'($urandom_range(1, 8)));
			else if (r < 75)
				write_reg(esst_pkg::REG_BEAT_COUNT, '0);
			else if (r < 85)
				write_reg(esst_pkg::REG_BEAT_COUNT, esst_pkg::CFG_W'(1023));
			else
				write_reg(esst_pkg::REG_BEAT_COUNT, esst_pkg::CFG_W'($urandom_range(1, 1023)));
		end
		if ($urandom_range(0, 9) < 6) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				write_reg(esst_pkg::REG_TPB, esst_pkg::CFG_W'($urandom_range(1, 64)));
			else if (r < 65)
				write_reg(esst_pkg::REG_TPB, esst_pkg::CFG_W'(960));
			else if (r < 75)
				write_reg(esst_pkg::REG_TPB, '0);
			else if (r < 85)
				write_reg(esst_pkg::REG_TPB, esst_pkg::CFG_W'(65535));
			else
				write_reg(esst_pkg::REG_TPB, esst_pkg::CFG_W'($urandom_range(0, 65535)));
		end
		if ($urandom_range(0, 9) < 6) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				write_reg(esst_pkg::REG_BPB, esst_pkg::CFG_W'($urandom_range(1, 8)));
			else if (r < 65)
				write_reg(esst_pkg::REG_BPB, '0);
			else if (r < 80)
				write_reg(esst_pkg::REG_BPB, esst_pkg::CFG_W'(255));
			else
				write_reg(esst_pkg::REG_BPB, esst_pkg::CFG_W'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 9) < 5)
			write_reg(esst_pkg::REG_MASK_LO, pick_mask());
		if ($urandom_range(0, 9) < 5)
			write_reg(esst_pkg::REG_MASK_HI, pick_mask());

		len = $urandom_range(30, 120);
		while (len > 0) begin
			if (cfg_mode == esst_pkg::MODE_EVERY || cfg_mode == esst_pkg::MODE_NEW ||
					cfg_mode == esst_pkg::MODE_LIST) begin
				// A list: normally opened by a list start, then a few notes drawn from
				// a small pitch pool so that repeats and changes both occur. Some lists
				// lack their start, and a sprinkling of notes are pure noise.
				list_len = $urandom_range(1, 12);
				foreach (pool[j]) begin
					raw = {$urandom, $urandom};
					pool[j] = raw[esst_pkg::PITCH_W-1:0];
				end
				for (int i = 0; i < list_len && len > 0; i++) begin
					raw = {$urandom, $urandom};
					if (i == 0)
						first = ($urandom_range(0, 9) != 0);
					else
						first = ($urandom_range(0, 29) == 0);
					pitch = ($urandom_range(0, 9) == 0) ? raw[esst_pkg::PITCH_W-1:0]
						: pool[$urandom_range(0, 2)];
					queue_trigger(random_tick(), pitch, first);
					len--;
				end
			end else begin
				raw = {$urandom, $urandom};
				if ((cfg_mode == esst_pkg::MODE_BEATS || cfg_mode == esst_pkg::MODE_BARS) &&
						$urandom_range(0, 3) != 0)
					queue_trigger(beat_tick(), raw[esst_pkg::PITCH_W-1:0],
						raw[esst_pkg::PITCH_W]);
				else
					queue_trigger(random_tick(), raw[esst_pkg::PITCH_W-1:0],
						raw[esst_pkg::PITCH_W]);
				len--;
			end
		end
		wait_idle();
	endtask

	initial begin
		// Everything the testbench drives is known from time zero.
		arst_n                = 1'b0;
		wr_en                 = 1'b0;
		wr_index              = '0;
		wr_data               = '0;
		trig_ch.valid         = 1'b0;
		trig_ch.tick          = '0;
		trig_ch.pitch         = '0;
		trig_ch.first_of_list = 1'b0;
		res_ch.ready          = 1'b0;

		cfg_mode       = esst_pkg::MODE_OFF;
		cfg_num_states = '0;
		cfg_start      = '0;
		cfg_beat_count = esst_pkg::BEAT_COUNT_RST;
		cfg_tpb        = esst_pkg::TPB_RST;
		cfg_bpb        = esst_pkg::BPB_RST;
		cfg_mask_lo    = '0;
		cfg_mask_hi    = '0;
		walk_state     = '0;
		seen_prev      = 1'b0;
		last_pitch     = '0;

		triggers_queued = 0;
		results_checked = 0;
		mismatches      = 0;
		send_gap        = 0;
		stall_left      = 0;
		hold_left       = 0;
		next_hold_at    = 150;
		quiet_cycles    = 0;
		no_idle         = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: the off mode with no states gives zero, even at the tick and
		// pitch extremes.
		queue_trigger('0, '0, 1'b1);
		queue_trigger(TICK_MAX, 7'd127, 1'b0);
		wait_idle();

		// Every note after the list start advances; four states from state two wrap around to zero.
		set_walk(esst_pkg::MODE_EVERY, 4, 2);
		queue_trigger(48'sd10, 7'd60, 1'b1);
		queue_trigger(48'sd20, 7'd60, 1'b0);
		queue_trigger(48'sd30, 7'd61, 1'b0);
		queue_trigger(48'sd40, 7'd62, 1'b0);
		wait_idle();

		// New-note mode, with a start state beyond the state count so it is clamped.
		set_walk(esst_pkg::MODE_NEW, 3, 15);
		queue_trigger(48'sd0, 7'd10, 1'b1);
		queue_trigger(48'sd1, 7'd10, 1'b0);
		queue_trigger(48'sd2, 7'd11, 1'b0);
		queue_trigger(48'sd3, 7'd11, 1'b0);
		wait_idle();

		// Walk up to a high state, then shrink the state count: with no list start
		// the stale state is folded into the new range before it advances.
		set_walk(esst_pkg::MODE_EVERY, 16, 13);
		queue_trigger(48'sd0, 7'd1, 1'b1);
		queue_trigger(48'sd5, 7'd1, 1'b0);
		wait_idle();
		write_reg(esst_pkg::REG_NUM_STATES, esst_pkg::CFG_W'(5));
		queue_trigger(48'sd9, 7'd1, 1'b0);
		wait_idle();

		// Whitelist at both ends of the pitch range; a listed first note advances too.
		set_walk(esst_pkg::MODE_LIST, 7, 0);
		write_reg(esst_pkg::REG_MASK_LO, 64'h1);
		write_reg(esst_pkg::REG_MASK_HI, 64'h8000_0000_0000_0000);
		queue_trigger(48'sd0, 7'd0, 1'b1);
		queue_trigger(48'sd0, 7'd5, 1'b0);
		queue_trigger(48'sd0, 7'd127, 1'b0);
		wait_idle();

		// Beat mode with zero beat length and count, both taken as one tick, on the
		// most negative tick and on minus one.
		set_walk(esst_pkg::MODE_BEATS, 16, 0);
		write_reg(esst_pkg::REG_TPB, '0);
		write_reg(esst_pkg::REG_BEAT_COUNT, '0);
		queue_trigger(TICK_MIN, 7'd64, 1'b0);
		queue_trigger(-48'sd1, 7'd63, 1'b1);
		wait_idle();

		// Bar mode at the largest period, with a state count above the maximum that
		// saturates to sixteen.
		set_walk(esst_pkg::MODE_BARS, 17, 3);
		write_reg(esst_pkg::REG_TPB, esst_pkg::CFG_W'(65535));
		write_reg(esst_pkg::REG_BPB, esst_pkg::CFG_W'(255));
		write_reg(esst_pkg::REG_BEAT_COUNT, esst_pkg::CFG_W'(1023));
		queue_trigger(-48'sd1, 7'd20, 1'b0);
		queue_trigger(TICK_MAX, 7'd21, 1'b0);
		wait_idle();

		// Unused mode codes, a single state and no states all give zero.
		set_walk(MODE_SPARE_A, 4, 1);
		queue_trigger(48'sd100, 7'd30, 1'b1);
		wait_idle();
		write_reg(esst_pkg::REG_MODE, esst_pkg::CFG_W'(MODE_SPARE_B));
		queue_trigger(48'sd200, 7'd31, 1'b0);
		wait_idle();
		set_walk(esst_pkg::MODE_EVERY, 1, 0);
		queue_trigger(48'sd300, 7'd32, 1'b0);
		wait_idle();
		set_walk(esst_pkg::MODE_BEATS, 0, 0);
		queue_trigger(48'sd400, 7'd33, 1'b0);
		wait_idle();

		while (triggers_queued < TARGET_EVENTS)
			random_phase();

		// All results are in; give the block time to show any stray extra transfer.
		wait_idle();
		repeat (80) @(posedge clk);
		if (mismatches == 0 && expected_states.size() == 0)
			$display("event_state_stepper_test OK");
		else
			$display("event_state_stepper_test NOT OK");
		$finish;
	end

endmodule
